### src/rational_arithmetic_unit_defines.svh
// Assertion macros shared by the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define RAU_ASSERT_IMP(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define RAU_ASSERT_NXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

### src/rau_pkg.sv
// Shared constants, opcodes, state type and helpers of the rational arithmetic unit.
package rau_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int NUM_W         = 64;
  localparam int DEN_W         = 63;
  localparam int MUL_CNT_W     = $clog2(OPERAND_WIDTH + 1);
  localparam int DIV_CNT_W     = $clog2(NUM_W + 1);

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_LESS = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_COMBINE,
    ST_GCD_SHIFT,
    ST_GCD_LOOP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  // Magnitude of a two's complement operand; the most negative value fits unsigned.
  function automatic logic [OPERAND_WIDTH-1:0] op_mag(input logic [OPERAND_WIDTH-1:0] x);
    return x[OPERAND_WIDTH-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

### src/rau_mul.sv
// Bit-serial shift-and-add multiplier for operand magnitudes.
module rau_mul import rau_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [OPERAND_WIDTH-1:0]     mcand,
  input  logic [OPERAND_WIDTH-1:0]     mplier,
  output logic                         done,
  output logic [2*OPERAND_WIDTH-1:0]   prod
);

  logic [OPERAND_WIDTH-1:0] hi;
  logic [OPERAND_WIDTH-1:0] lo;
  logic [OPERAND_WIDTH-1:0] md;
  logic [MUL_CNT_W-1:0]     cnt;
  logic                     busy;
  logic [OPERAND_WIDTH:0]   sum;

  // One multiplier bit per cycle: add the multiplicand into the high half, shift right.
  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, md} : '0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_W'(OPERAND_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi <= '0;
      lo <= mplier;
      md <= mcand;
    end else if (busy) begin
      hi <= sum[OPERAND_WIDTH:1];
      lo <= {sum[0], lo[OPERAND_WIDTH-1:1]};
    end
  end

endmodule

### src/rau_div.sv
// Dual restoring divider: two dividends by one common divisor, one quotient bit per cycle.
module rau_div import rau_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] divisor,
  input  logic [NUM_W-1:0] dividend_a,
  input  logic [NUM_W-1:0] dividend_b,
  output logic             done,
  output logic [NUM_W-1:0] quot_a,
  output logic [NUM_W-1:0] quot_b
);

  logic [NUM_W-1:0]     dv;
  logic [NUM_W-1:0]     ra;
  logic [NUM_W-1:0]     rb;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [NUM_W:0]       trial_a;
  logic [NUM_W:0]       trial_b;
  logic [NUM_W:0]       diff_a;
  logic [NUM_W:0]       diff_b;
  logic                 ge_a;
  logic                 ge_b;

  assign trial_a = {ra, quot_a[NUM_W-1]};
  assign trial_b = {rb, quot_b[NUM_W-1]};
  assign ge_a    = trial_a >= {1'b0, dv};
  assign ge_b    = trial_b >= {1'b0, dv};
  assign diff_a  = trial_a - {1'b0, dv};
  assign diff_b  = trial_b - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient registers start out holding the dividends and shift quotient bits in.
  always_ff @(posedge clk) begin
    if (start) begin
      dv     <= divisor;
      ra     <= '0;
      rb     <= '0;
      quot_a <= dividend_a;
      quot_b <= dividend_b;
    end else if (busy) begin
      ra     <= ge_a ? diff_a[NUM_W-1:0] : trial_a[NUM_W-1:0];
      rb     <= ge_b ? diff_b[NUM_W-1:0] : trial_b[NUM_W-1:0];
      quot_a <= {quot_a[NUM_W-2:0], ge_a};
      quot_b <= {quot_b[NUM_W-2:0], ge_b};
    end
  end

endmodule

### src/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer, combine step, gcd loop and output register.
//
// Usage. An input transaction carries an opcode and two rationals a = a_num/a_den and
// b = b_num/b_den; it is taken at a rising edge with in_valid high and in_stall low.
// The unit works on one transaction at a time and holds in_stall high from acceptance
// until the result has been written into the output register. Each input transaction
// yields exactly one output transaction (result_num, result_den, is_less, status),
// offered with out_valid and taken when out_stall is low.
// Sequence. The products are formed by one bit-serial multiplier, one operand bit per
// cycle: three products for add and subtract, two for the other operations. The binary
// gcd then takes one halving or one subtraction per cycle, and the shared restoring
// divider divides both values by the gcd. A comparison, a zero or an invalid result
// completes after the products and the combine step, and a fully reduced result after
// the gcd loop and the division. Unused opcodes go straight to the finish state.
// Reset (rst, synchronous) empties the output register and returns the sequencer to idle.
// When the receiver stalls, the finished result waits in the sequencer until the output
// register is free, so a new input transaction is taken as soon as the old one is handed on.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               opcode,
  input  logic signed [31:0]       a_num,
  input  logic signed [31:0]       a_den,
  input  logic signed [31:0]       b_num,
  input  logic signed [31:0]       b_den,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [NUM_W-1:0]  result_num,
  output logic [DEN_W-1:0]         result_den,
  output logic                     is_less,
  output logic                     status
);

  `include "rational_arithmetic_unit_defines.svh"

  state_t state;
  state_t state_next;

  // Captured transaction: the operands are reduced to their low OPERAND_WIDTH bits.
  logic [2:0]               op;
  logic [OPERAND_WIDTH-1:0] an;
  logic [OPERAND_WIDTH-1:0] ad;
  logic [OPERAND_WIDTH-1:0] bn;
  logic [OPERAND_WIDTH-1:0] bd;

  // Product index, products as magnitude and sign.
  logic [1:0]       k;
  logic [NUM_W-1:0] prod0;
  logic [NUM_W-1:0] prod1;
  logic [NUM_W-1:0] prod2;
  logic             ps0;
  logic             ps1;
  logic             ps2;

  // Working values of the gcd and the values to be reduced.
  logic [NUM_W-1:0] gu;
  logic [NUM_W-1:0] gv;
  logic [NUM_W-1:0] nkeep;
  logic [NUM_W-1:0] dkeep;
  logic             rneg;

  // Result waiting to enter the output register.
  logic [NUM_W-1:0] res_num;
  logic [DEN_W-1:0] res_den;
  logic             res_less;
  logic             res_status;

  logic                         accept;
  logic                         mul_start;
  logic                         mul_done;
  logic [OPERAND_WIDTH-1:0]     mul_x;
  logic [OPERAND_WIDTH-1:0]     mul_y;
  logic [2*OPERAND_WIDTH-1:0]   mul_prod;
  logic [NUM_W-1:0]             mul_prod_ext;
  logic                         mul_sign;
  logic                         mul_last;
  logic [1:0]                   k_next;
  logic                         div_start;
  logic                         div_done;
  logic [NUM_W-1:0]             quot_n;
  logic [NUM_W-1:0]             quot_d;
  logic                         out_free;

  // Combine step results.
  logic             qn;
  logic [NUM_W-1:0] nm;
  logic             nn;
  logic             less_raw;
  logic             den_zero_in;
  logic signed [NUM_W-1:0] lhs;
  logic signed [NUM_W-1:0] rhs;
  logic [NUM_W-1:0] nsat;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Operand selection for the product in progress.
  always_comb begin
    case (k)
      2'd0: begin
        mul_x = an;
        mul_y = (op == OP_MUL) ? bn : bd;
      end
      2'd1: begin
        mul_x = ad;
        mul_y = bn;
      end
      default: begin
        mul_x = ad;
        mul_y = (op == OP_DIV) ? bn : bd;
      end
    endcase
  end

  assign mul_prod_ext = NUM_W'(mul_prod);
  assign mul_sign     = (mul_prod != '0) && (mul_x[OPERAND_WIDTH-1] ^ mul_y[OPERAND_WIDTH-1]);
  assign mul_last     = (k == 2'd2) || ((k == 2'd1) && (op == OP_LESS));
  assign k_next       = ((k == 2'd0) && ((op == OP_MUL) || (op == OP_DIV))) ? 2'd2 : k + 2'd1;

  rau_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (op_mag(mul_x)),
    .mplier (op_mag(mul_y)),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  rau_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .divisor    (gu),
    .dividend_a (nkeep),
    .dividend_b (dkeep),
    .done       (div_done),
    .quot_a     (quot_n),
    .quot_b     (quot_d)
  );

  // Combine: signed sum or difference of the cross products, or the comparison.
  always_comb begin
    qn = ps1 ^ (op == OP_SUB);
    if ((op == OP_ADD) || (op == OP_SUB)) begin
      if (ps0 == qn) begin
        nm = prod0 + prod1;
        nn = ps0;
      end else if (prod0 >= prod1) begin
        nm = prod0 - prod1;
        nn = ps0;
      end else begin
        nm = prod1 - prod0;
        nn = qn;
      end
    end else begin
      nm = prod0;
      nn = ps0;
    end
    lhs         = ps0 ? -$signed(prod0) : $signed(prod0);
    rhs         = ps1 ? -$signed(prod1) : $signed(prod1);
    less_raw    = (ad[OPERAND_WIDTH-1] ^ bd[OPERAND_WIDTH-1]) ? (rhs < lhs) : (lhs < rhs);
    den_zero_in = (ad == '0) || (bd == '0);
    // A quotient of 2^63 cannot be represented and saturates.
    nsat        = quot_n[NUM_W-1] ? {1'b0, {(NUM_W-1){1'b1}}} : quot_n;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (opcode > OP_LESS) ? ST_FINISH : ST_MUL_GO;
        end
      end
      ST_MUL_GO: begin
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          state_next = mul_last ? ST_COMBINE : ST_MUL_GO;
        end
      end
      ST_COMBINE: begin
        if ((op == OP_LESS) || (prod2 == '0) || (nm == '0)) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_GCD_SHIFT;
        end
      end
      ST_GCD_SHIFT: begin
        if (gu[0] || gv[0]) begin
          state_next = ST_GCD_LOOP;
        end
      end
      ST_GCD_LOOP: begin
        if (gu[0] && (gv == '0)) begin
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall  = 1'b1;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_IDLE:   in_stall  = 1'b0;
      ST_MUL_GO: mul_start = 1'b1;
      ST_DIV_GO: div_start = 1'b1;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op         <= opcode;
          an         <= a_num[OPERAND_WIDTH-1:0];
          ad         <= a_den[OPERAND_WIDTH-1:0];
          bn         <= b_num[OPERAND_WIDTH-1:0];
          bd         <= b_den[OPERAND_WIDTH-1:0];
          k          <= 2'd0;
          res_num    <= '0;
          res_den    <= DEN_W'(1);
          res_less   <= 1'b0;
          res_status <= 1'b0;
        end
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          case (k)
            2'd0: begin
              prod0 <= mul_prod_ext;
              ps0   <= mul_sign;
            end
            2'd1: begin
              prod1 <= mul_prod_ext;
              ps1   <= mul_sign;
            end
            default: begin
              prod2 <= mul_prod_ext;
              ps2   <= mul_sign;
            end
          endcase
          k <= k_next;
        end
      end
      ST_COMBINE: begin
        if (op == OP_LESS) begin
          res_status <= den_zero_in;
          res_less   <= !den_zero_in && less_raw;
        end else if (prod2 == '0) begin
          res_den    <= '0;
          res_status <= 1'b1;
        end else begin
          gu    <= nm;
          gv    <= prod2;
          nkeep <= nm;
          dkeep <= prod2;
          rneg  <= nn ^ ps2;
        end
      end
      ST_GCD_SHIFT: begin
        // Common factors of two leave the gcd and both values together.
        if (!(gu[0] || gv[0])) begin
          gu    <= gu >> 1;
          gv    <= gv >> 1;
          nkeep <= nkeep >> 1;
          dkeep <= dkeep >> 1;
        end
      end
      ST_GCD_LOOP: begin
        if (!gu[0]) begin
          gu <= gu >> 1;
        end else if (gv == '0) begin
          gu <= gu;
        end else if (!gv[0]) begin
          gv <= gv >> 1;
        end else if (gu > gv) begin
          gu <= gv;
          gv <= gu - gv;
        end else begin
          gv <= gv - gu;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          res_num <= rneg ? (~nsat + 1'b1) : nsat;
          res_den <= quot_d[DEN_W-1:0];
        end
      end
      default: begin
        k <= k;
      end
    endcase
  end

  // Output register: a pending result is loaded whenever the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      result_num <= res_num;
      result_den <= res_den;
      is_less    <= res_less;
      status     <= res_status;
    end
  end

  `RAU_ASSERT_NXT(a_accept_blocks, accept, in_stall, "input taken while busy")
  `RAU_ASSERT_IMP(a_den_nonzero, out_valid && !status, result_den != '0, "zero denominator without error status")
  `RAU_ASSERT_IMP(a_gcd_odd, state == ST_DIV_GO, gu[0] && (gv == '0), "gcd not settled before division")
  `RAU_ASSERT_IMP(a_less_shape, out_valid && is_less, (result_num == '0) && !status, "comparison result carries a value")

endmodule

### tb/tb_rational_arithmetic_unit.sv
// Self-checking testbench of the rational arithmetic unit, with a built-in result predictor.
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  // Expected contents of one output transaction.
  typedef struct {
    logic signed [63:0] num;
    logic [62:0]        den;
    logic               less;
    logic               stat;
  } ratio_res_t;

  // One row of the directed table. When known is set, the typed-in result is also compared
  // with the predictor, so that the predictor itself is checked on the obvious cases.
  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] an, ad, bn, bd;
    bit                 known;
    ratio_res_t         res;
  } stim_row_t;

  localparam logic signed [31:0] MAXP = 32'sh7fffffff;
  localparam logic signed [31:0] MINN = 32'sh80000000;
  localparam logic [62:0]        DEN_ONE = 63'd1;
  localparam logic signed [63:0] NUM_SAT = 64'sh7fffffffffffffff;
  localparam int                 N_RANDOM = 600;
  localparam longint             CYCLE_LIMIT = 2000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         opcode = OP_ADD;
  logic signed [31:0] a_num = '0, a_den = 32'sd1, b_num = '0, b_den = 32'sd1;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] result_num;
  logic [62:0]        result_den;
  logic               is_less;
  logic               status;

  ratio_res_t pending_results[$];
  int         error_count = 0;
  int         results_seen = 0;
  longint     cycle_count = 0;
  bit         quiet_tail = 1'b0;

  rational_arithmetic_unit DUT (.*);

  always #5 clk = ~clk;

  // Run limit: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Magnitude of a signed 64-bit product, as an unsigned value.
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  // Binary gcd on magnitudes; gcd with zero gives the other operand.
  function automatic logic [63:0] gcd64(input logic [63:0] u, input logic [63:0] v);
    int sh;
    logic [63:0] t;
    sh = 0;
    if (u == 0) return v;
    if (v == 0) return u;
    while (((u | v) & 64'd1) == 0) begin
      u >>= 1; v >>= 1; sh++;
    end
    while (u[0] == 1'b0) u >>= 1;
    while (v != 0) begin
      while (v[0] == 1'b0) v >>= 1;
      if (u > v) begin
        t = u; u = v; v = t;
      end
      v = v - u;
    end
    return u << sh;
  endfunction

  // Predicts the reduced rational (or the comparison) for one input transaction.
  function automatic ratio_res_t reduce_ratio(input logic [2:0] op,
      input logic signed [31:0] an32, input logic signed [31:0] ad32,
      input logic signed [31:0] bn32, input logic signed [31:0] bd32);
    ratio_res_t r;
    logic signed [63:0] an, ad, bn, bd, p, q, n, d;
    logic [63:0] pm, qm, nmag, dmag, g;
    bit pn, qn, nneg, dneg, flip;
    an = an32; ad = ad32; bn = bn32; bd = bd32;
    r.num = '0; r.den = DEN_ONE; r.less = 1'b0; r.stat = 1'b0;
    nneg = 0; dneg = 0; nmag = 0; dmag = 0;
    if (op == OP_LESS) begin
      if (ad == 0 || bd == 0) begin
        r.stat = 1'b1;
        return r;
      end
      p = an * bd;
      q = bn * ad;
      flip = (ad < 0) != (bd < 0);
      r.less = flip ? (q < p) : (p < q);
      return r;
    end
    if (op > OP_LESS) return r;
    if (op == OP_ADD || op == OP_SUB) begin
      p = an * bd;
      q = ad * bn;
      pn = p < 0;
      qn = (q < 0) != (op == OP_SUB);
      pm = mag64(p); qm = mag64(q);
      if (pn == qn) begin
        nmag = pm + qm; nneg = pn;
      end else if (pm >= qm) begin
        nmag = pm - qm; nneg = pn;
      end else begin
        nmag = qm - pm; nneg = qn;
      end
      d = ad * bd;
    end else if (op == OP_MUL) begin
      n = an * bn; d = ad * bd;
      nmag = mag64(n); nneg = n < 0;
    end else begin
      n = an * bd; d = ad * bn;
      nmag = mag64(n); nneg = n < 0;
    end
    dmag = mag64(d); dneg = d < 0;
    if (dmag == 0) begin
      r.den = '0; r.stat = 1'b1;
      return r;
    end
    if (nmag == 0) return r;
    g = gcd64(nmag, dmag);
    nmag = nmag / g;
    dmag = dmag / g;
    if (dneg) nneg = !nneg;
    if (nmag > 64'h7fffffffffffffff) nmag = 64'h7fffffffffffffff;
    r.num = nneg ? -$signed(nmag) : $signed(nmag);
    r.den = dmag[62:0];
    return r;
  endfunction

  // Offers one transaction and waits until the unit takes it. The payload holds while stalled.
  // Valid is only dropped for an idle gap, so that back-to-back offers need no extra edge.
  task automatic send_item(input logic [2:0] op, input logic signed [31:0] an,
      input logic signed [31:0] ad, input logic signed [31:0] bn, input logic signed [31:0] bd);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op; a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
    pending_results.push_back(reduce_ratio(op, an, ad, bn, bd));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver side: random stall bursts, then none in the quiet tail.
  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 3);
        repeat (burst) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Output checker: every accepted result is matched field by field against the oldest
  // expectation.
  always @(posedge clk) begin
    ratio_res_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $error("result_num: unexpected transaction, actual %0d", result_num);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_num !== want.num) begin
          $error("result_num: expected %0d, actual %0d", want.num, result_num);
          error_count++;
        end
        if (result_den !== want.den) begin
          $error("result_den: expected %0d, actual %0d", want.den, result_den);
          error_count++;
        end
        if (is_less !== want.less) begin
          $error("is_less: expected %0b, actual %0b", want.less, is_less);
          error_count++;
        end
        if (status !== want.stat) begin
          $error("status: expected %0b, actual %0b", want.stat, status);
          error_count++;
        end
      end
    end
  end

  // Random operand: mostly small values so that gcd reduction really cancels, sometimes
  // full-range, sometimes an extreme, and now and then zero.
  function automatic logic signed [31:0] pick_operand(input bit den_like);
    case ($urandom_range(0, 9))
      0:       return den_like ? 32'sd1 : 32'sd0;
      1:       return MAXP;
      2:       return MINN;
      3, 4:    return $signed($urandom());
      5:       return -$signed(32'($urandom_range(1, 100)));
      default: return $signed(32'($urandom_range(1, 360)));
    endcase
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    ratio_res_t got;
    logic [2:0] op;
    logic signed [31:0] ad, bd;
    int i, wait_cycles;

    // Directed table: every operation, the extremes and each special case.
    rows = '{
      '{OP_ADD,  32'sd1, 32'sd2, 32'sd1, 32'sd3, 1, '{64'sd5, 63'd6, 1'b0, 1'b0}},
      '{OP_SUB,  32'sd1, 32'sd2, 32'sd1, 32'sd2, 1, '{64'sd0, DEN_ONE, 1'b0, 1'b0}},
      '{OP_MUL,  32'sd2, 32'sd3, 32'sd3, 32'sd4, 1, '{64'sd1, 63'd2, 1'b0, 1'b0}},
      '{OP_DIV,  32'sd2, 32'sd3, 32'sd4, 32'sd9, 1, '{64'sd3, 63'd2, 1'b0, 1'b0}},
      '{OP_LESS, 32'sd1, 32'sd3, 32'sd1, 32'sd2, 1, '{64'sd0, DEN_ONE, 1'b1, 1'b0}},
      '{OP_LESS, 32'sd1, 32'sd2, 32'sd1, 32'sd3, 1, '{64'sd0, DEN_ONE, 1'b0, 1'b0}},
      // Zero denominators set the error status.
      '{OP_ADD,  32'sd1, 32'sd0, 32'sd1, 32'sd2, 1, '{64'sd0, 63'd0, 1'b0, 1'b1}},
      '{OP_MUL,  32'sd1, 32'sd2, 32'sd1, 32'sd0, 1, '{64'sd0, 63'd0, 1'b0, 1'b1}},
      '{OP_DIV,  32'sd1, 32'sd2, 32'sd0, 32'sd5, 1, '{64'sd0, 63'd0, 1'b0, 1'b1}},
      '{OP_LESS, 32'sd1, 32'sd0, 32'sd1, 32'sd2, 1, '{64'sd0, DEN_ONE, 1'b0, 1'b1}},
      // Unused opcodes return the neutral result.
      '{3'd5,    32'sd7, 32'sd2, 32'sd1, 32'sd2, 1, '{64'sd0, DEN_ONE, 1'b0, 1'b0}},
      '{3'd6,    32'sd7, 32'sd0, 32'sd1, 32'sd0, 1, '{64'sd0, DEN_ONE, 1'b0, 1'b0}},
      '{3'd7,    MINN,   MINN,   MINN,   MINN,   1, '{64'sd0, DEN_ONE, 1'b0, 1'b0}},
      // A zero numerator is returned as 0/1.
      '{OP_MUL,  32'sd0, 32'sd7, 32'sd5, 32'sd3, 1, '{64'sd0, DEN_ONE, 1'b0, 1'b0}},
      // Negative denominators are normalised and respected in the comparison.
      '{OP_ADD,  32'sd1, -32'sd2, 32'sd0, 32'sd1, 1, '{-64'sd1, 63'd2, 1'b0, 1'b0}},
      '{OP_LESS, 32'sd1, -32'sd2, 32'sd0, 32'sd1, 1, '{64'sd0, DEN_ONE, 1'b1, 1'b0}},
      // Most negative operands: the saturation corner and full-scale products.
      '{OP_MUL,  MINN, 32'sd1, MINN, 32'sd1, 1, '{64'sh4000000000000000, DEN_ONE, 1'b0, 1'b0}},
      '{OP_SUB,  MINN, 32'sd1, MAXP, 32'sd1, 0, '{0, 0, 0, 0}},
      '{OP_ADD,  MINN, MAXP, MINN, MAXP, 0, '{0, 0, 0, 0}},
      '{OP_DIV,  MINN, MINN, 32'sd1, MINN, 0, '{0, 0, 0, 0}},
      '{OP_DIV,  MAXP, 32'sd1, MINN, MAXP, 0, '{0, 0, 0, 0}},
      '{OP_SUB,  MINN, -32'sd1, MINN, 32'sd1, 0, '{0, 0, 0, 0}},
      '{OP_LESS, MINN, MAXP, MAXP, MINN, 0, '{0, 0, 0, 0}},
      '{OP_MUL,  MAXP, MAXP, MAXP, MAXP, 1, '{64'sd1, DEN_ONE, 1'b0, 1'b0}}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) begin
      row = rows[k];
      if (row.known) begin
        got = reduce_ratio(row.op, row.an, row.ad, row.bn, row.bd);
        if (got.num !== row.res.num) begin
          $error("result_num: table row %0d expected %0d, predicted %0d",
                 k, row.res.num, got.num);
          error_count++;
        end
        if (got.den !== row.res.den) begin
          $error("result_den: table row %0d expected %0d, predicted %0d",
                 k, row.res.den, got.den);
          error_count++;
        end
        if (got.less !== row.res.less) begin
          $error("is_less: table row %0d expected %0b, predicted %0b",
                 k, row.res.less, got.less);
          error_count++;
        end
        if (got.stat !== row.res.stat) begin
          $error("status: table row %0d expected %0b, predicted %0b",
                 k, row.res.stat, got.stat);
          error_count++;
        end
      end
      send_item(row.op, row.an, row.ad, row.bn, row.bd);
    end

    // Random part: mostly valid operations, occasional unused opcode; zero denominators
    // are forced now and then for either operand. The last tenth runs without idling.
    for (i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - N_RANDOM / 10) quiet_tail = 1'b1;
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      ad = ($urandom_range(0, 24) == 0) ? 32'sd0 : pick_operand(1);
      bd = ($urandom_range(0, 24) == 0) ? 32'sd0 : pick_operand(1);
      send_item(op, pick_operand(0), ad, pick_operand(0), bd);
    end
    in_valid <= 1'b0;

    // Drain, then a short settling pause for anything unexpected.
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (500) @(posedge clk);

    $display("Covered %0d transactions: all opcodes, zero and negative denominators,",
             rows.size() + N_RANDOM);
    $display("operand extremes and random operands, with %0d results compared.", results_seen);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
